// ===== sv/ssrp_pkg.sv =====
// shared types, constants and codes of the serial schedule block
package ssrp_pkg;
    localparam int unsigned RESOURCES_DEF = 4;
    localparam int unsigned HORIZON_DEF   = 4096;
    localparam int unsigned MAX_TASKS_DEF = 256;
    localparam int unsigned NCFG          = 4;
    localparam int unsigned CAP_W         = 10;
    localparam int unsigned TIME_W        = 13;
    localparam int unsigned START_W       = 12;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_PRED  = 2'd1,
        ACT_PLACE = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIPE,
        ST_PRED,
        ST_SCAN,
        ST_BOOK,
        ST_DONE
    } t_state;

    // lane command from the sequencer
    typedef struct packed {
        logic              wipe;
        logic              rd;
        logic              wr;
        logic [CAP_W-1:0]  dem;
        logic [CAP_W-1:0]  cap;
    } t_lane_cmd;
endpackage

// ===== sv/ssrp_if.sv =====
// valid/ready channel carrying a generic payload
interface ssrp_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/ssrp_lane.sv =====
// one resource lane: usage profile memory with fit check and booking
module ssrp_lane
    import ssrp_pkg::*;
#(
    parameter int unsigned HORIZON = HORIZON_DEF,
    localparam int unsigned AW = $clog2(HORIZON)
) (
    input  logic            i_clk,
    input  t_lane_cmd       i_cmd,
    input  logic [AW-1:0]   i_addr,
    output logic            o_block
);
    logic [CAP_W-1:0] r_mem [HORIZON];
    logic [CAP_W-1:0] r_rd;
    logic [CAP_W:0]   w_sum;

    // profile memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wipe) begin
            r_mem[i_addr] <= '0;
        end else if (i_cmd.wr) begin
            r_mem[i_addr] <= CAP_W'(r_rd + i_cmd.dem);
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[i_addr];
        end
    end

    // booked usage plus demand against capacity
    assign w_sum   = {1'b0, r_rd} + {1'b0, i_cmd.dem};
    assign o_block = (i_cmd.dem != '0) && (w_sum > {1'b0, i_cmd.cap});
endmodule

// ===== sv/serial_schedule_resource_profile_top.sv =====
// top level: sequencer, finish table and resource lanes
//
// channel | dir | payload
// in      | in  | action, task_index, duration, demand_0..3
// out     | out | start_time, makespan, overflow
// cfg     | in  | write enable, index, capacity value
//
// a placement reads one slot of every lane per step; each scanned slot is read, then
// checked and advanced, and each booked slot is read, then written and advanced.
// a clear wipes HORIZON slots, one per cycle; reset runs the same wipe.
// a predecessor compares the registered finish table read with the pending start.
// input ready only in idle; the result sits in a register until taken.
module serial_schedule_resource_profile_top
    import ssrp_pkg::*;
#(
    parameter int unsigned RESOURCES = RESOURCES_DEF,
    parameter int unsigned HORIZON   = HORIZON_DEF,
    parameter int unsigned MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [CAP_W-1:0]  i_cfg_data,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_task_index,
    input  logic [7:0]        i_duration,
    input  logic [CAP_W-1:0]  i_demand_0,
    input  logic [CAP_W-1:0]  i_demand_1,
    input  logic [CAP_W-1:0]  i_demand_2,
    input  logic [CAP_W-1:0]  i_demand_3,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic [START_W-1:0] o_start_time,
    output logic [TIME_W-1:0] o_makespan,
    output logic              o_overflow,
    output logic              o_out_valid,
    input  logic              i_out_ready
);
    localparam int unsigned AW = $clog2(HORIZON);
    localparam int unsigned TW = $clog2(MAX_TASKS);
    localparam int unsigned PW = 18;

    t_state r_state, n_state;
    logic [CAP_W-1:0] r_cap [NCFG];
    logic [CAP_W-1:0] r_dem [NCFG];
    logic [7:0]       r_dur;
    logic [7:0]       r_idx;
    logic [PW-1:0]    r_t, r_tt, r_adv;
    logic             r_chk;
    logic [TIME_W-1:0] r_pend, r_mksp;
    logic [AW-1:0]    r_waddr;
    logic             r_wipe_last;
    logic [TIME_W-1:0] r_fin [MAX_TASKS];
    logic [TIME_W-1:0] r_fin_rd;
    logic             r_fin_ok;
    logic [RESOURCES-1:0] w_blk;
    logic             w_any;
    logic             w_acc;
    logic             w_demfail;
    logic [PW-1:0]    w_end;
    logic [AW-1:0]    w_addr;
    logic             w_wr;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NCFG; k++) r_cap[k] <= '0;
        end else if (i_cfg_we) begin
            r_cap[i_cfg_index] <= i_cfg_data;
        end
    end

    assign w_acc = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE) && !o_out_valid;
    assign w_end = r_t + PW'(r_dur);
    assign w_any = |w_blk;
    assign w_wr  = (r_state == ST_BOOK) && r_chk;

    // demand above capacity on any present resource
    always_comb begin
        w_demfail = 1'b0;
        for (int k = 0; k < NCFG; k++) begin
            if (k < RESOURCES && r_dem[k] > r_cap[k]) w_demfail = 1'b1;
        end
    end

    // lanes addressed by slot pointer or wipe pointer
    assign w_addr = (r_state == ST_WIPE) ? r_waddr : r_tt[AW-1:0];

    for (genvar g = 0; g < RESOURCES; g++) begin : g_lane
        t_lane_cmd w_cmd;
        always_comb begin
            w_cmd.wipe = (r_state == ST_WIPE);
            w_cmd.rd   = 1'b1;
            w_cmd.wr   = w_wr;
            w_cmd.dem  = (g < NCFG) ? r_dem[g % NCFG] : '0;
            w_cmd.cap  = (g < NCFG) ? r_cap[g % NCFG] : '0;
        end
        ssrp_lane #(.HORIZON(HORIZON)) u_lane (
            .i_clk  (i_clk),
            .i_cmd  (w_cmd),
            .i_addr (w_addr),
            .o_block(w_blk[g])
        );
    end

    // finish table
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && !o_overflow && r_fin_ok) begin
            r_fin[r_idx[TW-1:0]] <= w_end[TIME_W-1:0];
        end
        r_fin_rd <= r_fin[i_task_index[TW-1:0]];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    unique case (t_action'(i_action))
                        ACT_CLEAR: n_state = ST_WIPE;
                        ACT_PRED:  n_state = ST_PRED;
                        ACT_PLACE: n_state = ST_SCAN;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WIPE: if (r_wipe_last) n_state = ST_IDLE;
            ST_PRED: n_state = ST_IDLE;
            ST_SCAN: begin
                if (r_dur == '0 || w_demfail) n_state = ST_DONE;
                else if (r_t >= PW'(HORIZON) || w_end > PW'(HORIZON)) n_state = ST_DONE;
                else if (r_chk && w_any) n_state = ST_SCAN;
                else if (r_chk && (r_tt + 1'b1 == w_end)) n_state = ST_BOOK;
            end
            ST_BOOK: if (r_chk && (r_tt + 1'b1 == w_end)) n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WIPE;
            r_waddr <= '0;
            r_wipe_last <= 1'b0;
            r_pend <= '0;
            r_mksp <= '0;
            r_chk <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        r_dur <= i_duration;
                        r_idx <= i_task_index;
                        r_fin_ok <= ({24'd0, i_task_index} < MAX_TASKS);
                        r_dem[0] <= i_demand_0;
                        r_dem[1] <= i_demand_1;
                        r_dem[2] <= i_demand_2;
                        r_dem[3] <= i_demand_3;
                        r_t <= PW'(r_pend);
                        r_tt <= PW'(r_pend);
                        r_chk <= 1'b0;
                        r_waddr <= '0;
                        r_wipe_last <= 1'b0;
                        if (t_action'(i_action) == ACT_CLEAR) begin
                            r_pend <= '0;
                            r_mksp <= '0;
                        end
                    end
                end
                ST_WIPE: begin
                    r_waddr <= r_waddr + 1'b1;
                    r_wipe_last <= (r_waddr == AW'(HORIZON - 2));
                end
                ST_PRED: begin
                    if (r_fin_ok && r_fin_rd > r_pend) r_pend <= r_fin_rd;
                end
                ST_SCAN: begin
                    // alternate read and check of each slot
                    if (!r_chk) begin
                        r_chk <= 1'b1;
                    end else if (w_any) begin
                        r_t <= r_tt + 1'b1;
                        r_tt <= r_tt + 1'b1;
                        r_chk <= 1'b0;
                    end else if (r_tt + 1'b1 == w_end) begin
                        r_tt <= r_t;
                        r_chk <= 1'b0;
                    end else begin
                        r_tt <= r_tt + 1'b1;
                        r_chk <= 1'b0;
                    end
                end
                ST_BOOK: begin
                    if (!r_chk) r_chk <= 1'b1;
                    else begin
                        r_tt <= r_tt + 1'b1;
                        r_chk <= 1'b0;
                    end
                end
                ST_DONE: begin
                    r_pend <= '0;
                    o_out_valid <= 1'b1;
                    // a booked task may extend the makespan
                    if (!o_overflow && w_end > PW'(r_mksp)) r_mksp <= w_end[TIME_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && n_state == ST_DONE) begin
            if (r_dur == '0) begin
                o_overflow <= (r_t >= PW'(HORIZON));
            end else begin
                o_overflow <= 1'b1;
            end
        end else if (r_state == ST_BOOK && n_state == ST_DONE) begin
            o_overflow <= 1'b0;
        end
        if (r_state == ST_DONE) begin
            if (o_overflow) begin
                o_start_time <= '0;
                o_makespan <= r_mksp;
            end else begin
                o_start_time <= r_t[START_W-1:0];
                if (w_end > PW'(r_mksp)) begin
                    o_makespan <= w_end[TIME_W-1:0];
                end else begin
                    o_makespan <= r_mksp;
                end
            end
        end
    end
endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench of the serial schedule block with a built-in schedule predictor
module tb_top;
    import ssrp_pkg::*;

    typedef struct packed {
        t_action          act;
        logic [7:0]       idx;
        logic [7:0]       dur;
        logic [3:0][9:0]  dem;
    } item_t;

    typedef struct packed {
        logic [11:0] start;
        logic [12:0] mk;
        logic        ovf;
    } res_t;

    typedef struct {
        item_t it;
        bit    typed;
        res_t  res;
    } row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [9:0]  cfg_data;
    bit          failed;
    bit          typed_next;
    res_t        typed_res;
    row_t        rows [$];

    ssrp_if #(.T(item_t)) task_ch (.i_clk(i_clk));
    ssrp_if #(.T(res_t))  res_ch  (.i_clk(i_clk));

    serial_schedule_resource_profile_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_action     (task_ch.data.act),
        .i_task_index (task_ch.data.idx),
        .i_duration   (task_ch.data.dur),
        .i_demand_0   (task_ch.data.dem[0]),
        .i_demand_1   (task_ch.data.dem[1]),
        .i_demand_2   (task_ch.data.dem[2]),
        .i_demand_3   (task_ch.data.dem[3]),
        .i_in_valid   (task_ch.valid),
        .o_in_ready   (task_ch.ready),
        .o_start_time (res_ch.data.start),
        .o_makespan   (res_ch.data.mk),
        .o_overflow   (res_ch.data.ovf),
        .o_out_valid  (res_ch.valid),
        .i_out_ready  (res_ch.ready)
    );

    // schedule state mirrored by the predictor
    logic [9:0]  cap_q [4];
    logic [9:0]  profile [4][4096];
    logic [12:0] finish_q [256];
    int unsigned pend_start;
    int unsigned span_q;
    res_t        sched_q [$];
    int          placed_ids [$];
    int          last_placed;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hard stop
    initial begin
        #400000000;
        $display("simulation failed");
        $finish;
    end

    // predict one transaction, returns 1 when a result is due
    function automatic bit schedule_step(item_t it, output res_t r);
        int unsigned t, adv, d, tt;
        bit          fail, ok;
        r = '0;
        d = it.dur;
        case (it.act)
            ACT_CLEAR: begin
                foreach (profile[k, s]) profile[k][s] = '0;
                span_q = 0;
                pend_start = 0;
                return 1'b0;
            end
            ACT_PRED: begin
                if (finish_q[it.idx] > pend_start) pend_start = finish_q[it.idx];
                return 1'b0;
            end
            ACT_PLACE: begin
                t = pend_start;
                fail = 1'b0;
                if (d > 0)
                    for (int k = 0; k < 4; k++)
                        if (it.dem[k] > cap_q[k]) fail = 1'b1;
                while (!fail) begin
                    adv = t + 1;
                    ok = 1'b1;
                    if (t >= 4096 || t + d > 4096) begin
                        fail = 1'b1;
                        break;
                    end
                    for (int k = 0; k < 4 && ok; k++) begin
                        if (it.dem[k] == 0) continue;
                        for (tt = t; tt < t + d; tt++)
                            if (int'(profile[k][tt]) + int'(it.dem[k]) > int'(cap_q[k])) begin
                                ok = 1'b0;
                                if (tt + 1 > adv) adv = tt + 1;
                                break;
                            end
                    end
                    if (ok) break;
                    t = adv;
                end
                pend_start = 0;
                if (fail) begin
                    r.mk = span_q[12:0];
                    r.ovf = 1'b1;
                    return 1'b1;
                end
                for (int k = 0; k < 4; k++) begin
                    if (it.dem[k] == 0) continue;
                    for (tt = t; tt < t + d; tt++)
                        profile[k][tt] = profile[k][tt] + it.dem[k];
                end
                finish_q[it.idx] = 13'(t + d);
                placed_ids.insert(placed_ids.size(), int'(it.idx));
                last_placed = it.idx;
                if (t + d > span_q) span_q = t + d;
                r.start = t[11:0];
                r.mk = span_q[12:0];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // append one row to the directed table
    function automatic void add_row(item_t it, bit typed, res_t res);
        row_t rw;
        rw.it    = it;
        rw.typed = typed;
        rw.res   = res;
        rows.insert(rows.size(), rw);
    endfunction

    // send one transaction, then predict it on acceptance
    task automatic send_task(item_t it);
        int   gap;
        res_t r, exp_r;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            @(negedge i_clk);
            task_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        task_ch.valid <= 1'b1;
        task_ch.data  <= it;
        do @(posedge i_clk); while (!task_ch.ready);
        if (schedule_step(it, r)) begin
            exp_r = typed_next ? typed_res : r;
            sched_q.insert(sched_q.size(), exp_r);
        end
        typed_next = 1'b0;
    endtask

    // wait for an idle block, then write all capacities
    task automatic load_caps(logic [9:0] c0, logic [9:0] c1, logic [9:0] c2, logic [9:0] c3);
        logic [9:0] vals [4];
        vals = '{c0, c1, c2, c3};
        @(negedge i_clk);
        task_ch.valid <= 1'b0;
        while (sched_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        do @(posedge i_clk); while (!task_ch.ready);
        for (int k = 0; k < 4; k++) begin
            @(negedge i_clk);
            cfg_we    <= 1'b1;
            cfg_index <= 2'(k);
            cfg_data  <= vals[k];
            @(posedge i_clk);
            cap_q[k] = vals[k];
        end
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic item_t mk_item(t_action a, int idx, int dur,
                                      int d0, int d1, int d2, int d3);
        item_t it;
        it.act = a;
        it.idx = 8'(idx);
        it.dur = 8'(dur);
        it.dem = {10'(d3), 10'(d2), 10'(d1), 10'(d0)};
        return it;
    endfunction

    function automatic logic [9:0] pick_demand(logic [9:0] c);
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return '0;
        if (r == 3) return 10'($urandom_range(0, 1023));
        return 10'($urandom_range(0, c));
    endfunction

    // stimulus
    initial begin
        item_t it;
        int    r, npre;
        failed = 1'b0;
        typed_next = 1'b0;
        span_q = 0;
        pend_start = 0;
        last_placed = -1;
        foreach (cap_q[k]) cap_q[k] = '0;
        foreach (profile[k, s]) profile[k][s] = '0;
        foreach (finish_q[k]) finish_q[k] = '0;
        task_ch.valid = 1'b0;
        task_ch.data  = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        add_row(mk_item(ACT_PLACE, 0, 0, 1023, 1023, 1023, 1023), 1'b1, '{0, 0, 0});
        add_row(mk_item(ACT_PLACE, 1, 5, 0, 0, 0, 1), 1'b1, '{0, 0, 1});
        add_row(mk_item(ACT_PLACE, 2, 255, 1023, 0, 1, 0), 1'b1, '{0, 255, 0});
        add_row(mk_item(ACT_PLACE, 3, 10, 1, 0, 0, 0), 1'b0, '0);
        add_row(mk_item(ACT_PRED, 3, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_item(ACT_PRED, 2, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_item(ACT_PLACE, 4, 1, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_item(ACT_PLACE, 255, 255, 0, 1023, 0, 0), 1'b0, '0);
        add_row(mk_item(ACT_NONE, 170, 170, 682, 341, 682, 341), 1'b0, '0);
        add_row(mk_item(ACT_PRED, 255, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_item(ACT_PLACE, 5, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_item(ACT_PLACE, 170, 255, 0, 0, 1, 0), 1'b0, '0);
        add_row(mk_item(ACT_CLEAR, 85, 85, 341, 682, 341, 682), 1'b0, '0);
        add_row(mk_item(ACT_PLACE, 6, 255, 1023, 1023, 1, 0), 1'b1, '{0, 255, 0});
        add_row(mk_item(ACT_PLACE, 7, 1, 0, 0, 0, 0), 1'b1, '{0, 255, 0});
        load_caps(10'd1023, 10'd1023, 10'd1, 10'd0);
        foreach (rows[i]) begin
            typed_next = rows[i].typed;
            typed_res  = rows[i].res;
            send_task(rows[i].it);
        end

        // random phases, each opened with a clear
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: load_caps(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                             10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
                1: load_caps(10'd1023, 10'd1023, 10'd1023, 10'd1023);
                2: if (ph == 2) load_caps('0, '0, '0, '0);
                   else load_caps(10'($urandom_range(1, 15)), 10'($urandom_range(0, 15)),
                                  10'($urandom_range(1, 15)), 10'($urandom_range(1, 15)));
                default: load_caps(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                                   10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
            endcase
            send_task(mk_item(ACT_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 1023), 0, 0, $urandom_range(0, 1023)));
            if (ph % 4 == 3) begin
                // long chain of successors runs into the horizon
                for (int n = 0; n < 31; n++) begin
                    if (last_placed >= 0)
                        send_task(mk_item(ACT_PRED, last_placed, 0, 0, 0, 0, 0));
                    it = mk_item(ACT_PLACE, $urandom_range(0, 255), $urandom_range(150, 255),
                                 0, 0, 0, 0);
                    for (int k = 0; k < 4; k++)
                        it.dem[k] = ($urandom_range(0, 3) == 0) ? pick_demand(cap_q[k]) : '0;
                    send_task(it);
                end
            end else begin
                for (int n = 0; n < 36; n++) begin
                    r = $urandom_range(0, 99);
                    if (r < 5) begin
                        it = item_t'($urandom());
                        it.act = ACT_NONE;
                        send_task(it);
                    end else if (r < 15 && placed_ids.size() != 0) begin
                        send_task(mk_item(ACT_PRED,
                            placed_ids[$urandom_range(0, placed_ids.size() - 1)], 0, 0, 0, 0, 0));
                    end else begin
                        npre = (placed_ids.size() != 0) ? $urandom_range(0, 2) : 0;
                        for (int p = 0; p < npre; p++) begin
                            it = item_t'($urandom());
                            it.act = ACT_PRED;
                            it.idx = 8'(placed_ids[$urandom_range(0, placed_ids.size() - 1)]);
                            send_task(it);
                        end
                        it.act = ACT_PLACE;
                        it.idx = 8'($urandom_range(0, 255));
                        it.dur = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 20))
                                                            : 8'($urandom_range(0, 255));
                        for (int k = 0; k < 4; k++) it.dem[k] = pick_demand(cap_q[k]);
                        send_task(it);
                    end
                end
            end
        end

        // drain
        @(negedge i_clk);
        task_ch.valid <= 1'b0;
        while (sched_q.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (!failed) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // result side stalls
    initial begin
        int gap;
        res_ch.ready = 1'b0;
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                @(negedge i_clk);
                res_ch.ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        res_t e;
        if (res_ch.valid && res_ch.ready) begin
            if (sched_q.size() == 0) begin
                $display("%0t: unexpected result transaction %p", $realtime, res_ch.data);
                failed = 1'b1;
            end else begin
                e = sched_q.pop_front();
                if (res_ch.data.start !== e.start) begin
                    $display("%0t: start_time expected %0d actual %0d",
                             $realtime, e.start, res_ch.data.start);
                    failed = 1'b1;
                end
                if (res_ch.data.mk !== e.mk) begin
                    $display("%0t: makespan expected %0d actual %0d",
                             $realtime, e.mk, res_ch.data.mk);
                    failed = 1'b1;
                end
                if (res_ch.data.ovf !== e.ovf) begin
                    $display("%0t: overflow expected %0d actual %0d",
                             $realtime, e.ovf, res_ch.data.ovf);
                    failed = 1'b1;
                end
            end
        end
    end
endmodule

// ===== filelist.f =====
sv/ssrp_pkg.sv
sv/ssrp_if.sv
sv/ssrp_lane.sv
sv/serial_schedule_resource_profile_top.sv
tb/tb_top.sv
